// ----- src/lzsswd_pkg.sv -----
// ----------------------------------------------------------------------------
// lzsswd_pkg: shared types and constants of the LZSS window decoder
// Default geometry, token phase codes and sequencer states.
// ----------------------------------------------------------------------------
package lzsswd_pkg;

	// default geometry
	localparam int WINDOW_SIZE_DEF = 4096;
	localparam int MAX_MATCH_DEF   = 18;
	localparam int LENGTH_BIAS_DEF = 2;

	// flag byte is loaded with this sentinel above its eight flag bits
	localparam logic [7:0] FLAG_SENTINEL = 8'hff;

	// token phase; the fourth code is handled like the flag phase
	typedef enum logic [1:0] {
		PH_FLAG  = 2'd0,
		PH_TOKEN = 2'd1,
		PH_HIGH  = 2'd2
	} phase_t;

	// copy sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} state_t;

endpackage

// ----- src/lzsswd_in_if.sv -----
// ----------------------------------------------------------------------------
// lzsswd_in_if: compressed byte channel
// Valid/ready channel carrying one code byte and its section end mark.
// ----------------------------------------------------------------------------
interface lzsswd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       section_end;

	modport source (output valid, output code_byte, output section_end, input ready);
	modport sink   (input valid, input code_byte, input section_end, output ready);
endinterface

// ----- src/lzsswd_out_if.sv -----
// ----------------------------------------------------------------------------
// lzsswd_out_if: decompressed byte channel
// Valid/ready channel carrying one plain byte and the last-of-run mark.
// ----------------------------------------------------------------------------
interface lzsswd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] plain_byte;
	logic       run_last;

	modport source (output valid, output plain_byte, output run_last, input ready);
	modport sink   (input valid, input plain_byte, input run_last, output ready);
endinterface

// ----- src/lzss_window_decoder.sv -----
// Order: a literal byte goes from the literal holder to the output register in the emit step;
// a match byte is read from the window in the read step, then emitted. Each match high byte
// starts a copy of up to MAX_MATCH bytes; no code byte is taken until the copy ends, and the
// emit step waits for the output; the window port pair and copy sequencer set this order.
// Reset: arst_n clears all control state at once; the window needs no clearing
// pass, a fill count marks unwritten entries, which read as zero.
// ----------------------------------------------------------------------------
// lzss_window_decoder: LZSS decompressor with a history window
// Parses flag bytes, literals and match tokens and copies matches byte by
// byte out of the window through one shared read/write sequencer.
// ----------------------------------------------------------------------------
module lzss_window_decoder #(
	parameter int WINDOW_SIZE = lzsswd_pkg::WINDOW_SIZE_DEF,
	parameter int MAX_MATCH   = lzsswd_pkg::MAX_MATCH_DEF,
	parameter int LENGTH_BIAS = lzsswd_pkg::LENGTH_BIAS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	lzsswd_in_if.sink    code_in,
	lzsswd_out_if.source plain_out
);
	import lzsswd_pkg::*;

	localparam int ADDR_W = $clog2(WINDOW_SIZE);
	localparam int FILL_W = ADDR_W + 1;
	localparam int LEN_W  = $clog2(LENGTH_BIAS + 17);
	localparam logic [ADDR_W-1:0] WP_START = ADDR_W'(WINDOW_SIZE - MAX_MATCH);
	localparam logic [LEN_W-1:0]  LEN_ADD  = LEN_W'(LENGTH_BIAS + 1);
	localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_MATCH);

	// window memory
	logic [7:0] mem [WINDOW_SIZE];

	state_t            state_q, state_d;
	phase_t            phase_q;
	logic [15:0]       flag_q;
	logic [7:0]        held_q;
	logic [ADDR_W-1:0] wr_pos_q;
	logic [FILL_W-1:0] fill_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic [LEN_W-1:0]  remain_q;
	logic              lit_sel_q;
	logic [7:0]        lit_q;
	logic              end_q;
	logic [7:0]        rd_data_q;
	logic              rd_valid_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;

	logic              in_fire;
	logic              emit_go;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_off;
	logic              rd_hit;
	logic [7:0]        emit_byte;
	logic [11:0]       pos_full;
	logic [LEN_W-1:0]  len_raw;
	logic [LEN_W-1:0]  len;

	// match token decode
	assign pos_full = {code_in.code_byte[7:4], held_q};
	assign len_raw  = LEN_W'(code_in.code_byte[3:0]) + LEN_ADD;
	assign len      = (len_raw > LEN_MAX) ? LEN_MAX : len_raw;

	// entry was written this section if it lies within the fill from the start
	assign rd_off = rd_addr_q - WP_START;
	assign rd_hit = fill_q[ADDR_W] || ({1'b0, rd_off} < fill_q);

	assign emit_byte = lit_sel_q ? lit_q : (rd_valid_q ? rd_data_q : 8'h00);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (code_in.valid) begin
					priority case (phase_q)
						PH_TOKEN: if (flag_q[0]) state_d = ST_EMIT;
						PH_HIGH:  state_d = ST_READ;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ: state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_go) state_d = (remain_q == LEN_W'(1)) ? ST_IDLE : ST_READ;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		code_in.ready = (state_q == ST_IDLE);
		rd_en         = (state_q == ST_READ);
		emit_go       = (state_q == ST_EMIT) && (!out_valid_q || plain_out.ready);
	end

	assign in_fire = code_in.valid && code_in.ready;

	assign plain_out.valid      = out_valid_q;
	assign plain_out.plain_byte = out_byte_q;
	assign plain_out.run_last   = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// window port: read in the read step, write in the emit step
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q  <= mem[rd_addr_q];
			rd_valid_q <= rd_hit;
		end
		if (emit_go) mem[wr_pos_q] <= emit_byte;
	end

	// token parser and copy bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_FLAG;
			flag_q    <= '0;
			held_q    <= '0;
			wr_pos_q  <= WP_START;
			fill_q    <= '0;
			rd_addr_q <= '0;
			remain_q  <= '0;
			lit_sel_q <= 1'b0;
			end_q     <= 1'b0;
		end else if (in_fire) begin
			priority case (phase_q)
				PH_TOKEN: begin
					if (flag_q[0]) begin
						remain_q  <= LEN_W'(1);
						lit_sel_q <= 1'b1;
						end_q     <= code_in.section_end;
					end else if (code_in.section_end) begin
						phase_q  <= PH_FLAG;
						flag_q   <= '0;
						held_q   <= '0;
						wr_pos_q <= WP_START;
						fill_q   <= '0;
					end else begin
						held_q  <= code_in.code_byte;
						phase_q <= PH_HIGH;
					end
				end
				PH_HIGH: begin
					rd_addr_q <= pos_full[ADDR_W-1:0];
					remain_q  <= len;
					lit_sel_q <= 1'b0;
					end_q     <= code_in.section_end;
				end
				default: begin
					if (code_in.section_end) begin
						phase_q  <= PH_FLAG;
						flag_q   <= '0;
						held_q   <= '0;
						wr_pos_q <= WP_START;
						fill_q   <= '0;
					end else begin
						flag_q  <= {FLAG_SENTINEL, code_in.code_byte};
						phase_q <= PH_TOKEN;
					end
				end
			endcase
		end else if (emit_go) begin
			rd_addr_q <= rd_addr_q + ADDR_W'(1);
			remain_q  <= remain_q - LEN_W'(1);
			if ((remain_q == LEN_W'(1)) && end_q) begin
				// last byte of the section: back to the reset state
				phase_q  <= PH_FLAG;
				flag_q   <= '0;
				held_q   <= '0;
				wr_pos_q <= WP_START;
				fill_q   <= '0;
			end else begin
				wr_pos_q <= wr_pos_q + ADDR_W'(1);
				if (!fill_q[ADDR_W]) fill_q <= fill_q + FILL_W'(1);
				if (remain_q == LEN_W'(1)) begin
					// next flag bit; the sentinel says whether one is left
					flag_q  <= {1'b0, flag_q[15:1]};
					phase_q <= flag_q[9] ? PH_TOKEN : PH_FLAG;
				end
			end
		end
	end

	// literal byte holder
	always_ff @(posedge clk) begin
		if (in_fire) lit_q <= code_in.code_byte;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (plain_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_byte_q <= emit_byte;
			out_last_q <= (remain_q == LEN_W'(1));
		end
	end

	// checks
	a_remain_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (remain_q != '0))
		else $error("copy in progress with no bytes remaining");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW_SIZE))
		else $error("fill count beyond window size");

	a_wr_pos_track: assert property (@(posedge clk) disable iff (!arst_n)
		!fill_q[ADDR_W] |-> (wr_pos_q == WP_START + fill_q[ADDR_W-1:0]))
		else $error("write pointer out of step with fill count");

	a_section_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && end_q && (remain_q == LEN_W'(1))) |=>
		((fill_q == '0) && (wr_pos_q == WP_START) && (phase_q == PH_FLAG)))
		else $error("section end did not restore reset state");

	a_match_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (phase_q == PH_HIGH)) |=> (state_q == ST_READ))
		else $error("match token did not start a window read");

endmodule
